// ===== hw/rtl/dbnc_pkg.sv =====
// Shared types and constants for the multi-switch debouncer.
`default_nettype none
package dbnc_pkg;

    localparam int MAX_SW  = 4;
    localparam int CHAN_W  = 2;
    localparam int TIME_W  = 20;
    localparam int REGA_W  = 3;

    localparam logic [TIME_W-1:0] DEFAULT_DEBOUNCE = 20'd10000;

    localparam logic [REGA_W-1:0] REG_ENABLE     = 3'd0;
    localparam logic [REGA_W-1:0] REG_ACTIVE_LOW = 3'd1;
    localparam logic [REGA_W-1:0] REG_DEBOUNCE_0 = 3'd2;
    localparam logic [REGA_W-1:0] REG_DEBOUNCE_1 = 3'd3;
    localparam logic [REGA_W-1:0] REG_DEBOUNCE_2 = 3'd4;
    localparam logic [REGA_W-1:0] REG_DEBOUNCE_3 = 3'd5;

    localparam logic ACT_EDGE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef struct packed {
        logic              action;
        logic [CHAN_W-1:0] channel;
        logic              edge_level;
        logic [MAX_SW-1:0] pin_levels;
    } item_t;

    typedef struct packed {
        logic [MAX_SW-1:0] mask;
        logic [MAX_SW-1:0] closed;
    } rep_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dbnc_core.sv =====
// Debounce state and shared one-shot timer; builds the report set when the timer fires.
`default_nettype none
module dbnc_core #(
    parameter int NUM_SWITCHES = 4
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      proc,
    input  wire dbnc_pkg::item_t           item,
    input  wire logic [NUM_SWITCHES-1:0]   enable_mask,
    input  wire logic [NUM_SWITCHES-1:0]   active_low_mask,
    input  wire logic [dbnc_pkg::TIME_W-1:0] edge_time,
    output dbnc_pkg::rep_t                 report
);
    import dbnc_pkg::*;

    logic [NUM_SWITCHES-1:0] rec_reg, rec_next;
    logic [NUM_SWITCHES-1:0] chg_reg, chg_next;
    logic [TIME_W-1:0]       count_reg, count_next;
    logic [TIME_W-1:0]       cmp_reg, cmp_next;
    logic                    run_reg, run_next;

    logic [NUM_SWITCHES-1:0] pins;
    logic [NUM_SWITCHES-1:0] ch_bit;
    logic [TIME_W-1:0]       count_inc;
    logic                    ch_ok;
    logic                    fire;
    logic [NUM_SWITCHES-1:0] rep_mask;

    assign pins      = item.pin_levels[NUM_SWITCHES-1:0];
    assign ch_ok     = ({1'b0, item.channel} < (CHAN_W+1)'(NUM_SWITCHES));
    assign ch_bit    = NUM_SWITCHES'(1) << item.channel;
    assign count_inc = count_reg + TIME_W'(1);
    assign fire      = proc && (item.action == ACT_TICK) && run_reg && (count_inc >= cmp_reg);
    assign rep_mask  = fire ? (enable_mask & chg_reg & ~(pins ^ rec_reg)) : '0;

    assign report.mask   = MAX_SW'(rep_mask);
    assign report.closed = MAX_SW'(pins ^ active_low_mask);

    always_comb begin
        rec_next   = rec_reg;
        chg_next   = chg_reg;
        count_next = count_reg;
        cmp_next   = cmp_reg;
        run_next   = run_reg;
        if (proc) begin
            if (item.action == ACT_EDGE) begin
                if (ch_ok) begin
                    rec_next   = item.edge_level ? (rec_reg | ch_bit) : (rec_reg & ~ch_bit);
                    chg_next   = chg_reg | ch_bit;
                    cmp_next   = edge_time;
                    count_next = '0;
                    run_next   = 1'b1;
                end
            end else if (run_reg) begin
                count_next = count_inc;
                if (fire) begin
                    run_next = 1'b0;
                    chg_next = chg_reg & ~enable_mask;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_reg   <= '0;
            chg_reg   <= '0;
            count_reg <= '0;
            cmp_reg   <= '0;
            run_reg   <= 1'b0;
        end else begin
            rec_reg   <= rec_next;
            chg_reg   <= chg_next;
            count_reg <= count_next;
            cmp_reg   <= cmp_next;
            run_reg   <= run_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/dbnc_report.sv =====
// Report buffer: holds one firing's reports and sends them lowest channel first.
`default_nettype none
module dbnc_report (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        load,
    input  wire dbnc_pkg::rep_t              report_in,
    input  wire logic                        m_tready,
    output logic                             free,
    output logic                             m_tvalid,
    output logic [dbnc_pkg::CHAN_W-1:0]      m_channel,
    output logic                             m_closed,
    output logic                             m_last
);
    import dbnc_pkg::*;

    logic [MAX_SW-1:0] mask_reg, mask_next;
    logic [MAX_SW-1:0] closed_reg, closed_next;
    logic [MAX_SW-1:0] low_bit;
    logic [MAX_SW-1:0] mask_left;
    logic              pop;

    assign low_bit   = mask_reg & (~mask_reg + MAX_SW'(1));
    assign m_tvalid  = |mask_reg;
    assign pop       = m_tvalid && m_tready;
    assign mask_left = pop ? (mask_reg & ~low_bit) : mask_reg;
    assign free      = (mask_left == '0);
    assign m_last    = ((mask_reg & ~low_bit) == '0);
    assign m_closed  = |(closed_reg & low_bit);

    always_comb begin
        m_channel = '0;
        for (int i = MAX_SW - 1; i >= 0; i--) begin
            if (low_bit[i]) begin
                m_channel = CHAN_W'(i);
            end
        end
    end

    always_comb begin
        mask_next   = mask_left;
        closed_next = closed_reg;
        if (load) begin
            mask_next   = report_in.mask;
            closed_next = report_in.closed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        closed_reg <= closed_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/multi_switch_debouncer.sv =====
// Top level of the multi-switch debouncer: register port, input register and submodules.
//
//  Port    | Dir | Word contents
//  --------+-----+------------------------------------------------------------
//  s_*     | in  | tuser: action; tdata: channel, edge_level, pin_levels
//  m_*     | out | tdata: switch_channel, closed; tlast: last report of a tick
//  APB     | cfg | 0 enable, 1 active-low, 2..5 debounce time per channel
//
// An input word is registered, then processed: one word per cycle while no
// reports are pending. A firing tick loads up to four reports into the report
// buffer, sent one per cycle while m_tready is high; the next word is processed
// in the cycle the last one leaves. Synchronous active-low reset clears all control state; no clearing pass.
`default_nettype none
module multi_switch_debouncer #(
    parameter int NUM_SWITCHES = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [1:0] channel, [2] edge_level, [6:3] pin_levels
    input  wire logic [0:0]  s_tuser,   // [0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // [1:0] switch_channel, [2] closed
    output logic             m_tlast
);
    import dbnc_pkg::*;

    localparam int SEL_W = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;

    logic [NUM_SWITCHES-1:0] en_reg, en_next;
    logic [NUM_SWITCHES-1:0] al_reg, al_next;
    logic [TIME_W-1:0]       dbt_reg  [NUM_SWITCHES];
    logic [TIME_W-1:0]       dbt_next [NUM_SWITCHES];

    logic              in_valid_reg, in_valid_next;
    item_t             item_reg, item_next;
    item_t             s_item;
    logic              accept;
    logic              proc;
    logic              free;
    logic              wr;
    logic [REGA_W-1:0] reg_idx;
    logic [TIME_W-1:0] edge_time;
    rep_t              report;
    logic [CHAN_W-1:0] out_channel;
    logic              out_closed;

    // register port
    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_comb begin
        en_next = en_reg;
        al_next = al_reg;
        for (int i = 0; i < NUM_SWITCHES; i++) begin
            dbt_next[i] = dbt_reg[i];
            if (wr && (reg_idx == REG_DEBOUNCE_0 + REGA_W'(i))) begin
                dbt_next[i] = pwdata[TIME_W-1:0];
            end
        end
        if (wr && (reg_idx == REG_ENABLE)) begin
            en_next = pwdata[NUM_SWITCHES-1:0];
        end
        if (wr && (reg_idx == REG_ACTIVE_LOW)) begin
            al_next = pwdata[NUM_SWITCHES-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx) inside
            REG_ENABLE:     prdata = 32'(en_reg);
            REG_ACTIVE_LOW: prdata = 32'(al_reg);
            REG_DEBOUNCE_0, REG_DEBOUNCE_1, REG_DEBOUNCE_2, REG_DEBOUNCE_3: begin
                for (int i = 0; i < NUM_SWITCHES; i++) begin
                    if (reg_idx == REG_DEBOUNCE_0 + REGA_W'(i)) begin
                        prdata = 32'(dbt_reg[i]);
                    end
                end
            end
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg <= '0;
            al_reg <= '0;
            for (int i = 0; i < NUM_SWITCHES; i++) begin
                dbt_reg[i] <= DEFAULT_DEBOUNCE;
            end
        end else begin
            en_reg <= en_next;
            al_reg <= al_next;
            for (int i = 0; i < NUM_SWITCHES; i++) begin
                dbt_reg[i] <= dbt_next[i];
            end
        end
    end

    // input register
    assign s_item.action     = s_tuser[0];
    assign s_item.channel    = s_tdata[1:0];
    assign s_item.edge_level = s_tdata[2];
    assign s_item.pin_levels = s_tdata[6:3];

    assign proc     = in_valid_reg && free;
    assign s_tready = !in_valid_reg || proc;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        item_next     = item_reg;
        if (accept) begin
            in_valid_next = 1'b1;
            item_next     = s_item;
        end else if (proc) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    // out-of-range channels are dropped in the core before this value is used
    assign edge_time = dbt_reg[item_reg.channel[SEL_W-1:0]];

    dbnc_core #(
        .NUM_SWITCHES(NUM_SWITCHES)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .proc            (proc),
        .item            (item_reg),
        .enable_mask     (en_reg),
        .active_low_mask (al_reg),
        .edge_time       (edge_time),
        .report          (report)
    );

    dbnc_report u_report (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (proc),
        .report_in (report),
        .m_tready  (m_tready),
        .free      (free),
        .m_tvalid  (m_tvalid),
        .m_channel (out_channel),
        .m_closed  (out_closed),
        .m_last    (m_tlast)
    );

    assign m_tdata = {5'b0, out_closed, out_channel};

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for multi_switch_debouncer: table-driven and random traffic.
`timescale 1ns / 1ps
module tb;
    import dbnc_pkg::*;

    typedef struct packed {
        logic              action;
        logic [CHAN_W-1:0] channel;
        logic              edge_level;
        logic [MAX_SW-1:0] pin_levels;
        logic              has_exp;
        logic [CHAN_W-1:0] exp_ch;
        logic              exp_closed;
    } switch_word_t;

    typedef struct packed {
        logic [CHAN_W-1:0] ch;
        logic              closed;
        logic              last;
    } switch_report_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [1:0] channel, [2] edge_level, [6:3] pin_levels
    logic [0:0]  s_tuser = '0;   // [0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // [1:0] switch_channel, [2] closed
    logic        m_tlast;

    multi_switch_debouncer #(.NUM_SWITCHES(MAX_SW)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #10 aclk = ~aclk;

    // register shadow
    logic [MAX_SW-1:0] cfg_en = '0;
    logic [MAX_SW-1:0] cfg_al = '0;
    logic [TIME_W-1:0] cfg_dly [MAX_SW] = '{DEFAULT_DEBOUNCE, DEFAULT_DEBOUNCE,
                                            DEFAULT_DEBOUNCE, DEFAULT_DEBOUNCE};
    // debouncer state
    logic [MAX_SW-1:0] rec_lv = '0;
    logic [MAX_SW-1:0] chg = '0;
    logic [TIME_W-1:0] tcount = '0;
    logic [TIME_W-1:0] tcmp = '0;
    logic              trun = 1'b0;

    logic [MAX_SW-1:0] gen_lv;
    switch_word_t      switch_words [$];
    switch_report_t    pending_reports [$];
    int                err_count = 0;
    int                phase_no = -1;
    int                hold_left = 0;
    logic              hold_done = 1'b0;
    wire               calm = (phase_no == 3);

    // words on the bus, in order, so typed expectations survive packing
    switch_word_t debounce_cache [$];

    switch_word_t directed_rows [19] = '{
        '{ACT_TICK, 2'd0, 1'b0, 4'hF, 1'b0, 2'd0, 1'b0},  // timer stopped
        '{ACT_EDGE, 2'd0, 1'b1, 4'hF, 1'b0, 2'd0, 1'b0},
        '{ACT_TICK, 2'd3, 1'b1, 4'h1, 1'b1, 2'd0, 1'b1},  // zero delay fires at once
        '{ACT_EDGE, 2'd1, 1'b0, 4'h0, 1'b0, 2'd0, 1'b0},
        '{ACT_EDGE, 2'd2, 1'b1, 4'h0, 1'b0, 2'd0, 1'b0},
        '{ACT_TICK, 2'd0, 1'b0, 4'h4, 1'b0, 2'd0, 1'b0},
        '{ACT_TICK, 2'd0, 1'b0, 4'h4, 1'b0, 2'd0, 1'b0},
        '{ACT_EDGE, 2'd3, 1'b1, 4'h0, 1'b0, 2'd0, 1'b0},  // max delay
        '{ACT_TICK, 2'd0, 1'b0, 4'h8, 1'b0, 2'd0, 1'b0},
        '{ACT_TICK, 2'd0, 1'b0, 4'h8, 1'b0, 2'd0, 1'b0},
        '{ACT_EDGE, 2'd1, 1'b1, 4'h0, 1'b0, 2'd0, 1'b0},  // restart while running
        '{ACT_TICK, 2'd0, 1'b0, 4'h0, 1'b0, 2'd0, 1'b0},  // levels mismatch
        '{ACT_TICK, 2'd0, 1'b0, 4'hF, 1'b0, 2'd0, 1'b0},
        '{ACT_EDGE, 2'd0, 1'b0, 4'hF, 1'b0, 2'd0, 1'b0},
        '{ACT_EDGE, 2'd1, 1'b1, 4'h0, 1'b0, 2'd0, 1'b0},
        '{ACT_EDGE, 2'd2, 1'b0, 4'h0, 1'b0, 2'd0, 1'b0},
        '{ACT_EDGE, 2'd3, 1'b1, 4'h0, 1'b0, 2'd0, 1'b0},
        '{ACT_EDGE, 2'd0, 1'b1, 4'h0, 1'b0, 2'd0, 1'b0},
        '{ACT_TICK, 2'd0, 1'b0, 4'hB, 1'b0, 2'd0, 1'b0}   // all four report
    };

    task automatic flag_mismatch(input string msg);
        $display("%0t: mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic void debounce_step(input switch_word_t w);
        switch_report_t found [$];
        switch_report_t r;
        if (w.action == ACT_EDGE) begin
            rec_lv[w.channel] = w.edge_level;
            chg[w.channel] = 1'b1;
            tcmp = cfg_dly[w.channel];
            tcount = '0;
            trun = 1'b1;
            return;
        end
        if (!trun) return;
        tcount = tcount + 1'b1;
        if (tcount < tcmp) return;
        trun = 1'b0;
        for (int i = 0; i < MAX_SW; i++) begin
            if (cfg_en[i] && chg[i]) begin
                chg[i] = 1'b0;
                if (w.pin_levels[i] == rec_lv[i]) begin
                    r.ch = CHAN_W'(i);
                    r.closed = w.pin_levels[i] ^ cfg_al[i];
                    r.last = 1'b0;
                    found.push_back(r);
                end
            end
        end
        if (found.size() > 0) found[found.size()-1].last = 1'b1;
        if (w.has_exp) begin
            r.ch = w.exp_ch;
            r.closed = w.exp_closed;
            r.last = 1'b1;
            pending_reports.push_back(r);
        end else begin
            foreach (found[i]) pending_reports.push_back(found[i]);
        end
    endfunction

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                debounce_step(debounce_cache.pop_front());
            if (!s_tvalid || s_tready) begin
                if (switch_words.size() > 0 && (calm || $urandom_range(99) >= 33)) begin
                    switch_word_t w;
                    w = switch_words.pop_front();
                    debounce_cache.push_back(w);
                    s_tvalid <= 1'b1;
                    s_tuser <= w.action;
                    s_tdata <= {1'b0, w.pin_levels, w.edge_level, w.channel};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        switch_report_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_reports.size() == 0) begin
                    flag_mismatch($sformatf("unexpected report ch %0d closed %0d",
                                            m_tdata[1:0], m_tdata[2]));
                end else begin
                    want = pending_reports.pop_front();
                    if (m_tdata[1:0] !== want.ch)
                        flag_mismatch($sformatf("switch_channel %0d, want %0d",
                                                m_tdata[1:0], want.ch));
                    if (m_tdata[2] !== want.closed)
                        flag_mismatch($sformatf("closed %0d on ch %0d, want %0d",
                                                m_tdata[2], want.ch, want.closed));
                    if (m_tlast !== want.last)
                        flag_mismatch($sformatf("tlast %0d on ch %0d, want %0d",
                                                m_tlast, want.ch, want.last));
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else if (phase_no == 1 && !hold_done && m_tvalid) begin
                hold_left <= 80;
                hold_done <= 1'b1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 33);
            end
        end
    end

    task automatic apb_write(input logic [REGA_W-1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(input logic [MAX_SW-1:0] en, input logic [MAX_SW-1:0] al,
                              input logic [TIME_W-1:0] d0, input logic [TIME_W-1:0] d1,
                              input logic [TIME_W-1:0] d2, input logic [TIME_W-1:0] d3);
        apb_write(REG_ENABLE, {28'b0, en});
        apb_write(REG_ACTIVE_LOW, {28'b0, al});
        apb_write(REG_DEBOUNCE_0, {12'b0, d0});
        apb_write(REG_DEBOUNCE_1, {12'b0, d1});
        apb_write(REG_DEBOUNCE_2, {12'b0, d2});
        apb_write(REG_DEBOUNCE_3, {12'b0, d3});
        cfg_en = en;
        cfg_al = al;
        cfg_dly[0] = d0;
        cfg_dly[1] = d1;
        cfg_dly[2] = d2;
        cfg_dly[3] = d3;
    endtask

    task automatic push_word(input logic act, input logic [CHAN_W-1:0] ch, input logic lv,
                             input logic [MAX_SW-1:0] pins);
        switch_word_t w;
        w = '{act, ch, lv, pins, 1'b0, 2'd0, 1'b0};
        if (act == ACT_EDGE) gen_lv[ch] = lv;
        switch_words.push_back(w);
    endtask

    // mostly edge bursts followed by enough ticks to fire (unless the delay exceeds 12), pins near the recorded levels
    task automatic queue_traffic(input int n_items);
        int made;
        int k;
        int ticks;
        logic [CHAN_W-1:0] ch;
        logic [MAX_SW-1:0] flip;
        logic [TIME_W-1:0] t;
        made = 0;
        gen_lv = rec_lv;
        while (made < n_items) begin
            if ($urandom_range(99) < 75) begin
                k = $urandom_range(1, 4);
                t = '0;
                repeat (k) begin
                    ch = CHAN_W'($urandom_range(3));
                    t = cfg_dly[ch];
                    push_word(ACT_EDGE, ch, 1'($urandom_range(1)),
                              MAX_SW'($urandom_range(15)));
                end
                ticks = (t > 12) ? 3 : ((t == 0) ? 1 : int'(t)) + $urandom_range(2);
                repeat (ticks) begin
                    flip = '0;
                    for (int b = 0; b < MAX_SW; b++)
                        if ($urandom_range(4) == 0) flip[b] = 1'b1;
                    push_word(ACT_TICK, CHAN_W'($urandom_range(3)), 1'($urandom_range(1)),
                              gen_lv ^ flip);
                end
                made += k + ticks;
            end else begin
                push_word(1'($urandom_range(1)), CHAN_W'($urandom_range(3)),
                          1'($urandom_range(1)), MAX_SW'($urandom_range(15)));
                made++;
            end
        end
    endtask

    task automatic wait_drained();
        while (switch_words.size() != 0 || s_tvalid || pending_reports.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    initial begin
        logic [TIME_W-1:0] d [MAX_SW];
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_config(4'hF, 4'hA, 20'd0, 20'd1, 20'd2, 20'hFFFFF);
        foreach (directed_rows[i]) switch_words.push_back(directed_rows[i]);
        wait_drained();
        for (int p = 0; p < 6; p++) begin
            for (int i = 0; i < MAX_SW; i++) d[i] = TIME_W'($urandom_range(8));
            case (p)
                0: set_config(4'h0, 4'hF, d[0], d[1], d[2], d[3]);
                1: set_config(4'hF, 4'h0, d[0], d[1], d[2], d[3]);
                2: set_config(4'h5, 4'hA, d[0], d[1], d[2], d[3]);
                5: begin
                    d[CHAN_W'($urandom_range(3))] = 20'hFFFFF;
                    set_config(MAX_SW'($urandom_range(15)), MAX_SW'($urandom_range(15)),
                               d[0], d[1], d[2], d[3]);
                end
                default: set_config(MAX_SW'($urandom_range(15)), MAX_SW'($urandom_range(15)),
                                    d[0], d[1], d[2], d[3]);
            endcase
            phase_no = p;
            queue_traffic(55);
            wait_drained();
        end
        repeat (10) @(posedge aclk);
        if (pending_reports.size() != 0) flag_mismatch("reports still expected at end");
        if (err_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
